[hdl/fld_pkg.sv]
// Package with command codes and shared widths for the line drawer.
package fld_pkg;

    localparam logic [1:0] REQ_FILL  = 2'd0;
    localparam logic [1:0] REQ_PIXEL = 2'd1;
    localparam logic [1:0] REQ_LINE  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam int CoordW = 12;
    localparam int SizeW  = 9;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic [23:0] color_t;

endpackage

[hdl/framebuffer_line_drawer_unit.sv]
// Top level of the frame store line drawer with its command sequencer.
// After reset a clearing pass writes black to the whole store, with busy high.
// Fill writes one pixel per cycle through the single memory write port; a read registers the
// address, then the store data, then the result. Pixel: one clipped square stamp; line: one
// stamp per Bresenham point. One result strobe per command, the receiver cannot stall.
// rst_n is asynchronous; screen registers reset to 256; a new command is taken while done is high.
module framebuffer_line_drawer_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  fld_pkg::coord_t x0,
    input  fld_pkg::coord_t y0,
    input  fld_pkg::coord_t x1,
    input  fld_pkg::coord_t y1,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [3:0]  thickness,
    output logic        done,
    output logic [7:0]  read_red,
    output logic [7:0]  read_green,
    output logic [7:0]  read_blue,
    output logic        read_hit,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fld_pkg::*;

    localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
    localparam int AddrW = $clog2(Depth);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    // Signed working width for coordinates, clamps and error terms.
    localparam int SW = 16;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_FILL  = 4'd2;
    localparam logic [3:0] ST_SETUP = 4'd3;
    localparam logic [3:0] ST_STAMP = 4'd4;
    localparam logic [3:0] ST_LSTEP = 4'd5;
    localparam logic [3:0] ST_RADDR = 4'd6;
    localparam logic [3:0] ST_RWAIT = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;
    localparam logic [3:0] ST_LINIT = 4'd9;

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;

    logic [SizeW-1:0] width_reg, height_reg;
    logic [3:0]  state_reg;
    logic        line_reg;
    logic signed [SW-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic signed [SW-1:0] dx_reg, dy_reg, err_reg;
    logic signed [1:0] ix_reg, iy_reg;
    logic        xmaj_reg;
    logic signed [SW-1:0] sx_reg, ex_reg, ey_reg, px_reg, py_reg;
    logic [3:0]  thick_reg;
    color_t      color_reg;
    logic [AddrW-1:0] row_reg;
    logic [AddrW:0] cnt_reg;
    logic        hit_reg_n;
    logic        req_last_read;
    logic        wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [AddrW-1:0] rd_addr_reg;
    color_t      rd_data_reg;
    color_t      mem [Depth];

    // Effective screen size, limited to the store.
    logic [WW-1:0] act_w;
    logic [HW-1:0] act_h;
    assign act_w = (int'(width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_reg);
    assign act_h = (int'(height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_reg);

    assign pready = 1'b1;
    assign busy   = (state_reg != ST_IDLE);
    always_comb
    begin
        prdata = '0;
        case (paddr)
            ADDR_WIDTH:  prdata = 32'(width_reg);
            ADDR_HEIGHT: prdata = 32'(height_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SizeW'(256);
            height_reg <= SizeW'(256);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_WIDTH)  width_reg  <= pwdata[SizeW-1:0];
            if (paddr == ADDR_HEIGHT) height_reg <= pwdata[SizeW-1:0];
        end
    end

    // Clamped square bounds for the stamp about (xa, ya).
    logic signed [SW-1:0] t_s, sx_c, ex_c, sy_c, ey_c, wm1, hm1;
    assign t_s  = SW'(thick_reg);
    assign wm1  = SW'(act_w) - SW'(1);
    assign hm1  = SW'(act_h) - SW'(1);
    always_comb
    begin
        sx_c = xa_reg - t_s;
        ex_c = xa_reg + t_s;
        sy_c = ya_reg - t_s;
        ey_c = ya_reg + t_s;
        if (sx_c < 0) sx_c = '0;
        if (sy_c < 0) sy_c = '0;
        if (ex_c > wm1) ex_c = wm1;
        if (ey_c > hm1) ey_c = hm1;
    end

    // Line step decision, one Bresenham iteration per use.
    logic line_end;
    logic minor;
    assign line_end = xmaj_reg ? (xa_reg == xb_reg) : (ya_reg == yb_reg);
    assign minor = (err_reg > 0) ||
                   (err_reg == 0 && (xmaj_reg ? (ix_reg > 0) : (iy_reg > 0)));

    assign wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_FILL) ||
                     (state_reg == ST_STAMP && px_reg <= ex_reg && py_reg <= ey_reg);
    assign wr_addr = (state_reg == ST_STAMP) ? AddrW'(row_reg + AddrW'(px_reg))
                                             : cnt_reg[AddrW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= (state_reg == ST_CLEAR) ? '0 : color_reg;
        rd_data_reg <= mem[rd_addr_reg];
    end

    logic signed [SW-1:0] ddx, ddy;
    assign ddx = SW'(x1) - SW'(x0);
    assign ddy = SW'(y1) - SW'(y0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (AddrW+1)'(Depth - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (start)
                    begin
                        case (req_type)
                            REQ_FILL:
                                state_reg <= (act_w == '0 || act_h == '0) ? ST_DONE : ST_FILL;
                            REQ_PIXEL: state_reg <= ST_SETUP;
                            REQ_LINE:  state_reg <= ST_SETUP;
                            REQ_READ:  state_reg <= ST_RADDR;
                            default:   state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_FILL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (AddrW+1)'(act_w * act_h - 1)) state_reg <= ST_DONE;
                end
                ST_SETUP:
                begin
                    state_reg <= ST_STAMP;
                end
                ST_STAMP:
                begin
                    if (!(px_reg <= ex_reg && py_reg <= ey_reg) ||
                        (px_reg >= ex_reg && py_reg >= ey_reg))
                        state_reg <= (line_reg && !line_end) ? ST_LSTEP : ST_DONE;
                end
                ST_LSTEP:
                begin
                    state_reg <= ST_SETUP;
                end
                ST_RADDR:
                begin
                    state_reg <= ST_RWAIT;
                end
                ST_RWAIT:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    done      <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                color_reg <= {red, green, blue};
                thick_reg <= thickness;
                line_reg  <= (req_type == REQ_LINE);
                xa_reg <= SW'(x0);
                ya_reg <= SW'(y0);
                xb_reg <= SW'(x1);
                yb_reg <= SW'(y1);
                ix_reg <= (ddx > 0) ? 2'sd1 : ((ddx < 0) ? -2'sd1 : 2'sd0);
                iy_reg <= (ddy > 0) ? 2'sd1 : ((ddy < 0) ? -2'sd1 : 2'sd0);
                dx_reg <= ((ddx < 0) ? -ddx : ddx) <<< 1;
                dy_reg <= ((ddy < 0) ? -ddy : ddy) <<< 1;
                xmaj_reg <= ((ddx < 0) ? -ddx : ddx) >= ((ddy < 0) ? -ddy : ddy);
                err_reg  <= (((ddx < 0) ? -ddx : ddx) >= ((ddy < 0) ? -ddy : ddy))
                            ? (((ddy < 0) ? -ddy : ddy) <<< 1) - ((ddx < 0) ? -ddx : ddx)
                            : (((ddx < 0) ? -ddx : ddx) <<< 1) - ((ddy < 0) ? -ddy : ddy);
                rd_addr_reg <= AddrW'(AddrW'($unsigned(y0)) * AddrW'(act_w) +
                               AddrW'($unsigned(x0)));
                hit_reg_n   <= (SW'(x0) >= 0) && (SW'(x0) < SW'(act_w)) &&
                               (SW'(y0) >= 0) && (SW'(y0) < SW'(act_h));
            end
            ST_SETUP:
            begin
                sx_reg <= sx_c;
                ex_reg <= ex_c;
                ey_reg <= ey_c;
                px_reg <= sx_c;
                py_reg <= sy_c;
                row_reg <= AddrW'(AddrW'(sy_c) * AddrW'(act_w));
            end
            ST_STAMP:
            begin
                if (px_reg >= ex_reg)
                begin
                    px_reg  <= sx_reg;
                    py_reg  <= py_reg + 1'b1;
                    row_reg <= row_reg + AddrW'(act_w);
                end
                else
                    px_reg <= px_reg + 1'b1;
            end
            ST_LSTEP:
            begin
                if (xmaj_reg)
                begin
                    if (minor) ya_reg <= ya_reg + SW'(iy_reg);
                    err_reg <= err_reg - (minor ? dx_reg : '0) + dy_reg;
                    xa_reg  <= xa_reg + SW'(ix_reg);
                end
                else
                begin
                    if (minor) xa_reg <= xa_reg + SW'(ix_reg);
                    err_reg <= err_reg - (minor ? dy_reg : '0) + dx_reg;
                    ya_reg  <= ya_reg + SW'(iy_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            read_hit   <= hit_reg_n && (req_last_read);
            read_red   <= (hit_reg_n && req_last_read) ? rd_data_reg[23:16] : 8'd0;
            read_green <= (hit_reg_n && req_last_read) ? rd_data_reg[15:8]  : 8'd0;
            read_blue  <= (hit_reg_n && req_last_read) ? rd_data_reg[7:0]   : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start) req_last_read <= (req_type == REQ_READ);
    end
endmodule

[hdl/fld_checker.sv]
// Port-level checker for the line drawer, bound to the top level.
module fld_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic read_hit,
    input logic [7:0] read_red
);
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after start");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_miss_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !read_hit) |-> (read_red == 8'd0)) else $error("miss not black");
endmodule

bind framebuffer_line_drawer_unit fld_checker u_fld_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .read_hit(read_hit), .read_red(read_red)
);

[bench/fld_bench_pkg.sv]
// Register addresses of the screen size port, shared by the bench stimulus and the checker.
package fld_bench_pkg;

    localparam logic [2:0] ADDR_SCREEN_W = 3'd0;
    localparam logic [2:0] ADDR_SCREEN_H = 3'd4;

endpackage

[bench/fld_scoreboard.sv]
// Checker that mirrors the frame store, predicts every read result and compares it.
module fld_scoreboard #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  req_type,
    input  fld_pkg::coord_t x0,
    input  fld_pkg::coord_t y0,
    input  fld_pkg::coord_t x1,
    input  fld_pkg::coord_t y1,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [3:0]  thickness,
    input  logic        done,
    input  logic [7:0]  read_red,
    input  logic [7:0]  read_green,
    input  logic [7:0]  read_blue,
    input  logic        read_hit,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          failures,
    output int          pending
);
    import fld_pkg::*;
    import fld_bench_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       hit;
    } readback_t;

    color_t          pixels [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic [SizeW-1:0] width_reg;
    logic [SizeW-1:0] height_reg;
    readback_t       readbacks [$];

    function automatic int active_w();
        return (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int active_h();
        return (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    // Square of half size t around (x,y), clipped to the active screen.
    function automatic void paint_square(int x, int y, color_t c, int t);
        int sx, ex, sy, ey, aw, ah;
        aw = active_w();
        ah = active_h();
        sx = (x - t < 0) ? 0 : x - t;
        sy = (y - t < 0) ? 0 : y - t;
        ex = (x + t > aw - 1) ? aw - 1 : x + t;
        ey = (y + t > ah - 1) ? ah - 1 : y + t;
        for (int py = sy; py <= ey; py++)
            for (int px = sx; px <= ex; px++)
                pixels[py * aw + px] = c;
    endfunction

    // Bresenham walk with doubled deltas; a zero error steps the minor axis only
    // when the major axis runs in the positive direction.
    function automatic void trace_line(int xa, int ya, int xb, int yb, color_t c, int t);
        int dx, dy, sxs, sys, err;
        dx = xb - xa;
        dy = yb - ya;
        sxs = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
        sys = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
        dx = ((dx < 0) ? -dx : dx) * 2;
        dy = ((dy < 0) ? -dy : dy) * 2;
        paint_square(xa, ya, c, t);
        if (dx >= dy)
        begin
            err = dy - dx / 2;
            while (xa != xb)
            begin
                if (err > 0 || (err == 0 && sxs > 0))
                begin
                    err -= dx;
                    ya += sys;
                end
                err += dy;
                xa += sxs;
                paint_square(xa, ya, c, t);
            end
        end
        else
        begin
            err = dx - dy / 2;
            while (ya != yb)
            begin
                if (err > 0 || (err == 0 && sys > 0))
                begin
                    err -= dy;
                    xa += sxs;
                end
                err += dx;
                ya += sys;
                paint_square(xa, ya, c, t);
            end
        end
    endfunction

    function automatic readback_t apply_command();
        readback_t rb;
        color_t    c;
        int        xa, ya, aw, ah;
        rb = '0;
        c = {red, green, blue};
        xa = int'(x0);
        ya = int'(y0);
        aw = active_w();
        ah = active_h();
        case (req_type)
            REQ_FILL:
                for (int i = 0; i < aw * ah; i++) pixels[i] = c;
            REQ_PIXEL:
                paint_square(xa, ya, c, int'(thickness));
            REQ_LINE:
                trace_line(xa, ya, int'(x1), int'(y1), c, int'(thickness));
            default:
                if (xa >= 0 && xa < aw && ya >= 0 && ya < ah)
                begin
                    {rb.r, rb.g, rb.b} = pixels[ya * aw + xa];
                    rb.hit = 1'b1;
                end
        endcase
        return rb;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        readback_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH * MAX_HEIGHT; i++) pixels[i] = '0;
            width_reg  = SizeW'(256);
            height_reg = SizeW'(256);
            readbacks.delete();
            failures = 0;
            pending  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_SCREEN_W) width_reg = pwdata[SizeW-1:0];
                else if (paddr == ADDR_SCREEN_H) height_reg = pwdata[SizeW-1:0];
            end
            if (done)
            begin
                if (readbacks.size() == 0)
                begin
                    $error("result strobe with no command outstanding");
                    failures++;
                end
                else
                begin
                    want = readbacks.pop_front();
                    if (read_red !== want.r)
                    begin
                        $error("read_red expected %0d got %0d", want.r, read_red);
                        failures++;
                    end
                    if (read_green !== want.g)
                    begin
                        $error("read_green expected %0d got %0d", want.g, read_green);
                        failures++;
                    end
                    if (read_blue !== want.b)
                    begin
                        $error("read_blue expected %0d got %0d", want.b, read_blue);
                        failures++;
                    end
                    if (read_hit !== want.hit)
                    begin
                        $error("read_hit expected %0d got %0d", want.hit, read_hit);
                        failures++;
                    end
                end
            end
            if (start && !busy) readbacks.push_back(apply_command());
            pending = readbacks.size();
        end
    end

endmodule

[bench/framebuffer_line_drawer_unit_test.sv]
// Bench top: drives drawing commands and screen sizes, and reports the verdict.
module framebuffer_line_drawer_unit_test;
    import fld_pkg::*;
    import fld_bench_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    coord_t      x0, y0, x1, y1;
    logic [7:0]  red, green, blue;
    logic [3:0]  thickness;
    logic        done;
    logic [7:0]  read_red, read_green, read_blue;
    logic        read_hit;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int failures;
    int pending;
    int quiet_cycles;
    int cur_w, cur_h;
    int last_x, last_y;
    bit allow_idle;
    int kind_count [4];
    int reads_hit;

    framebuffer_line_drawer_unit DUT (.*);

    fld_scoreboard checker_inst (
        .clk, .rst_n, .start, .busy, .req_type, .x0, .y0, .x1, .y1,
        .red, .green, .blue, .thickness, .done, .read_red, .read_green,
        .read_blue, .read_hit, .psel, .penable, .pwrite, .pready, .paddr,
        .pwdata, .failures, .pending
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (done && read_hit) reads_hit <= reads_hit + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic issue(logic [1:0] kind, int xa, int ya, int xb, int yb,
                         logic [23:0] c, int t);
        if (allow_idle && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 12)) @(negedge clk);
        req_type = kind;
        x0 = coord_t'(xa);
        y0 = coord_t'(ya);
        x1 = coord_t'(xb);
        y1 = coord_t'(yb);
        {red, green, blue} = c;
        thickness = 4'(t);
        start = 1'b1;
        while (busy) @(negedge clk);
        @(negedge clk);
        start = 1'b0;
        kind_count[kind]++;
    endtask

    task automatic reg_write(logic [2:0] addr, int value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = {$urandom_range(0, 1) ? 23'($urandom) : 23'd0, 9'(value)};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Size changes only happen with the drawer idle and every result in.
    task automatic set_screen(int w, int h);
        while (pending != 0 || busy) @(negedge clk);
        repeat (4) @(negedge clk);
        reg_write(ADDR_SCREEN_W, w);
        reg_write(ADDR_SCREEN_H, h);
        cur_w = (w > 256) ? 256 : w;
        cur_h = (h > 256) ? 256 : h;
    endtask

    function automatic int pick_coord(int dim);
        if ($urandom_range(0, 99) < 12) return int'($signed(12'($urandom)));
        return $urandom_range(0, dim + 11) - 6;
    endfunction

    task automatic random_command();
        int r, xa, ya, xb, yb, t;
        bit far;
        r = $urandom_range(0, 99);
        xa = pick_coord(cur_w);
        ya = pick_coord(cur_h);
        xb = pick_coord(cur_w);
        yb = pick_coord(cur_h);
        far = (xa < -6 || ya < -6 || xb < -6 || yb < -6 ||
               xa > cur_w + 5 || ya > cur_h + 5 || xb > cur_w + 5 || yb > cur_h + 5);
        if (r < 8)
        begin
            issue(REQ_FILL, xa, ya, xb, yb, 24'($urandom), $urandom_range(0, 15));
        end
        else if (r < 35)
        begin
            t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
            issue(REQ_PIXEL, xa, ya, xb, yb, 24'($urandom), t);
            last_x = xa;
            last_y = ya;
        end
        else if (r < 65)
        begin
            t = far ? $urandom_range(0, 1) : $urandom_range(0, 4);
            issue(REQ_LINE, xa, ya, xb, yb, 24'($urandom), t);
            last_x = xb;
            last_y = yb;
        end
        else
        begin
            // Most reads land near the last thing drawn so edges of stamps get probed.
            if ($urandom_range(0, 9) < 6)
            begin
                xa = last_x + $urandom_range(0, 8) - 4;
                ya = last_y + $urandom_range(0, 8) - 4;
            end
            issue(REQ_READ, xa, ya, xb, yb, 24'($urandom), $urandom_range(0, 15));
        end
    endtask

    initial
    begin
        int dims [10][2];
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_READ;
        x0 = '0; y0 = '0; x1 = '0; y1 = '0;
        red = '0; green = '0; blue = '0;
        thickness = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        quiet_cycles = 0;
        reads_hit = 0;
        cur_w = 256;
        cur_h = 256;
        last_x = 0;
        last_y = 0;
        allow_idle = 1'b1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed part on the reset screen size, then a small screen.
        issue(REQ_READ, 0, 0, 0, 0, 24'hFFFFFF, 0);
        issue(REQ_READ, 255, 255, 0, 0, 24'h0, 0);
        issue(REQ_READ, 256, 0, 0, 0, 24'h0, 0);
        issue(REQ_READ, -1, 5, 0, 0, 24'h0, 0);
        issue(REQ_READ, -2048, 2047, 0, 0, 24'h0, 0);
        issue(REQ_PIXEL, 0, 0, 0, 0, 24'hFF00FF, 15);
        issue(REQ_PIXEL, 255, 255, 0, 0, 24'h00FF00, 0);
        issue(REQ_PIXEL, -2048, -2048, 0, 0, 24'h123456, 15);
        issue(REQ_READ, 15, 15, 0, 0, 24'h0, 0);
        issue(REQ_READ, 16, 0, 0, 0, 24'h0, 0);
        issue(REQ_READ, 255, 255, 0, 0, 24'h0, 0);
        issue(REQ_LINE, -2048, -2048, 2047, 2047, 24'hA5A5A5, 0);
        issue(REQ_READ, 100, 100, 0, 0, 24'h0, 0);
        issue(REQ_LINE, 10, 10, 14, 12, 24'h0000FF, 0);
        issue(REQ_LINE, 14, 22, 10, 20, 24'h00FF00, 0);
        issue(REQ_LINE, 30, 30, 32, 34, 24'hFF0000, 1);
        issue(REQ_LINE, 42, 44, 40, 40, 24'hFFFF00, 1);
        issue(REQ_LINE, 50, 50, 50, 50, 24'h00FFFF, 2);
        issue(REQ_READ, 12, 11, 0, 0, 24'h0, 0);
        issue(REQ_READ, 12, 21, 0, 0, 24'h0, 0);
        issue(REQ_FILL, 0, 0, 0, 0, 24'h808080, 0);
        issue(REQ_READ, 128, 77, 0, 0, 24'h0, 0);
        set_screen(16, 16);
        issue(REQ_LINE, 0, 0, 15, 3, 24'h3C3C3C, 15);
        issue(REQ_READ, 15, 15, 0, 0, 24'h0, 0);
        issue(REQ_READ, 16, 3, 0, 0, 24'h0, 0);

        dims = '{'{1, 1}, '{0, 7}, '{9, 0}, '{511, 2}, '{3, 511}, '{40, 25},
                 '{256, 3}, '{0, 0}, '{0, 0}, '{24, 24}};
        dims[7] = '{$urandom_range(1, 48), $urandom_range(1, 48)};
        dims[8] = '{$urandom_range(1, 48), $urandom_range(1, 48)};
        for (int p = 0; p < 10; p++)
        begin
            set_screen(dims[p][0], dims[p][1]);
            if (p == 9) allow_idle = 1'b0;
            for (int n = 0; n < 48; n++) random_command();
        end

        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        $display("Covered %0d fills, %0d stamps, %0d lines, %0d reads (%0d on screen)",
                 kind_count[REQ_FILL], kind_count[REQ_PIXEL], kind_count[REQ_LINE],
                 kind_count[REQ_READ], reads_hit);
        $display("across twelve screen settings including zero, one and oversized values.");
        if (failures == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
